FILE: src/deq_pkg.sv
package deq_pkg;

    localparam int DEQ_CAPACITY = 64;
    localparam int DEQ_IDX_W    = $clog2(DEQ_CAPACITY);
    localparam int DEQ_CNT_W    = $clog2(DEQ_CAPACITY + 1);

    // Field widths of the stream payloads.
    localparam int DEQ_MODE_W  = 3;
    localparam int DEQ_WORD_W  = 64;
    localparam int DEQ_FILL_W  = 7;
    localparam int DEQ_ERR_W   = 2;

    localparam int DEQ_S_TDATA_W = 72;
    localparam int DEQ_M_TDATA_W = 144;

    localparam logic [DEQ_MODE_W-1:0] MODE_NONE       = 3'd0;
    localparam logic [DEQ_MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [DEQ_MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
    localparam logic [DEQ_MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [DEQ_MODE_W-1:0] MODE_POP_BACK   = 3'd4;

    localparam logic [DEQ_ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [DEQ_ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [DEQ_ERR_W-1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic exec;      // apply the accepted operation to pointers and store
        logic rd_en;     // read front and back entries
        logic load_out;  // move the result into the output register
    } deq_cmd_t;

endpackage

FILE: src/deq_ctrl.sv
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     m_tready,
    output logic     m_tvalid,
    output deq_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic       accept;
    logic       load_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // The output register is free when empty or when its beat leaves now.
    assign load_ok  = (state_reg == ST_LOAD) && (!m_tvalid_reg || m_tready);

    assign cmd.exec     = accept;
    assign cmd.rd_en    = (state_reg == ST_READ);
    assign cmd.load_out = load_ok;
    assign m_tvalid     = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (load_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_ok) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

FILE: src/deq_datapath.sv
module deq_datapath
    import deq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  deq_cmd_t              cmd,
    input  logic [DEQ_MODE_W-1:0] mode,
    input  logic [DEQ_WORD_W-1:0] value,
    output logic [DEQ_WORD_W-1:0] front_word,
    output logic [DEQ_WORD_W-1:0] back_word,
    output logic [DEQ_FILL_W-1:0] fill_count,
    output logic                  is_empty,
    output logic [DEQ_ERR_W-1:0]  error_code
);

    localparam logic [DEQ_CNT_W-1:0] CAP_CNT  = DEQ_CNT_W'(DEQ_CAPACITY);
    localparam logic [DEQ_CNT_W:0]   CAP_SUM  = (DEQ_CNT_W + 1)'(DEQ_CAPACITY);
    localparam logic [DEQ_IDX_W-1:0] LAST_IDX = DEQ_IDX_W'(DEQ_CAPACITY - 1);

    logic [DEQ_WORD_W-1:0] mem [DEQ_CAPACITY];

    logic [DEQ_IDX_W-1:0] head_reg;
    logic [DEQ_IDX_W-1:0] head_next;
    logic [DEQ_CNT_W-1:0] count_reg;
    logic [DEQ_CNT_W-1:0] count_next;
    logic [DEQ_ERR_W-1:0] err_reg;
    logic [DEQ_ERR_W-1:0] err_next;

    logic                 is_push;
    logic                 is_pop;
    logic                 wr_en;
    logic [DEQ_IDX_W-1:0] wr_addr;
    logic [DEQ_IDX_W-1:0] head_dec;
    logic [DEQ_IDX_W-1:0] head_inc;
    logic [DEQ_IDX_W-1:0] tail_addr;
    logic [DEQ_IDX_W-1:0] back_addr;
    logic [DEQ_CNT_W-1:0] back_off;

    logic [DEQ_WORD_W-1:0] rd_front_reg;
    logic [DEQ_WORD_W-1:0] rd_back_reg;

    logic [DEQ_WORD_W-1:0] front_reg;
    logic [DEQ_WORD_W-1:0] back_reg;
    logic [DEQ_FILL_W-1:0] fill_reg;
    logic                  empty_reg;
    logic [DEQ_ERR_W-1:0]  code_reg;

    // Head plus an offset up to the capacity, wrapped around the ring.
    function automatic logic [DEQ_IDX_W-1:0] ring_add(
        input logic [DEQ_IDX_W-1:0] base,
        input logic [DEQ_CNT_W-1:0] off
    );
        logic [DEQ_CNT_W:0] sum;
        sum = (DEQ_CNT_W + 1)'(base) + (DEQ_CNT_W + 1)'(off);
        if (sum >= CAP_SUM) begin
            sum = sum - CAP_SUM;
        end
        return sum[DEQ_IDX_W-1:0];
    endfunction

    assign is_push = (mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK);
    assign is_pop  = (mode == MODE_POP_FRONT) || (mode == MODE_POP_BACK);

    assign head_dec  = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_addr = ring_add(head_reg, count_reg);
    assign back_off  = (count_reg == '0) ? '0 : count_reg - 1'b1;
    assign back_addr = ring_add(head_reg, back_off);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        err_next   = err_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_addr;
        if (cmd.exec) begin
            err_next = ERR_OK;
            if (is_push) begin
                if (count_reg == CAP_CNT) begin
                    err_next = ERR_FULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (mode == MODE_PUSH_FRONT) begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end
                end
            end else if (is_pop) begin
                if (count_reg == '0) begin
                    err_next = ERR_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                    if (mode == MODE_POP_FRONT) begin
                        head_next = head_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            err_reg   <= ERR_OK;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= value;
        end
        if (cmd.rd_en) begin
            rd_front_reg <= mem[head_reg];
            rd_back_reg  <= mem[back_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            front_reg <= (count_reg == '0) ? '0 : rd_front_reg;
            back_reg  <= (count_reg == '0) ? '0 : rd_back_reg;
            fill_reg  <= DEQ_FILL_W'(count_reg);
            empty_reg <= (count_reg == '0);
            code_reg  <= err_reg;
        end
    end

    assign front_word = front_reg;
    assign back_word  = back_reg;
    assign fill_count = fill_reg;
    assign is_empty   = empty_reg;
    assign error_code = code_reg;

endmodule

FILE: src/double_ended_queue.sv
// Double-ended queue of 64-bit words in a 64-entry ring store.
// After an input beat is accepted, the store write, the registered two-port read
// of front and back, and the output register load follow one another. The load
// waits while an untaken beat is held; no new beat is accepted until it is done.
// Reset clears the head pointer, the count, the error and the output valid flag;
// the store contents are not cleared and no clearing pass is needed.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // mode [2:0], value [66:3], zero fill above
    input  logic [DEQ_S_TDATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // front_word [63:0], back_word [127:64], fill_count [134:128],
    // is_empty [135], error_code [137:136], zero fill above
    output logic [DEQ_M_TDATA_W-1:0] m_tdata
);

    localparam int OUT_USED_W = 2 * DEQ_WORD_W + DEQ_FILL_W + 1 + DEQ_ERR_W;

    deq_cmd_t              cmd;
    logic [DEQ_MODE_W-1:0] mode;
    logic [DEQ_WORD_W-1:0] value;
    logic [DEQ_WORD_W-1:0] front_word;
    logic [DEQ_WORD_W-1:0] back_word;
    logic [DEQ_FILL_W-1:0] fill_count;
    logic                  is_empty;
    logic [DEQ_ERR_W-1:0]  error_code;

    assign mode  = s_tdata[DEQ_MODE_W-1:0];
    assign value = s_tdata[DEQ_MODE_W +: DEQ_WORD_W];

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    deq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .mode       (mode),
        .value      (value),
        .front_word (front_word),
        .back_word  (back_word),
        .fill_count (fill_count),
        .is_empty   (is_empty),
        .error_code (error_code)
    );

    assign m_tdata = {{(DEQ_M_TDATA_W - OUT_USED_W){1'b0}},
                      error_code, is_empty, fill_count, back_word, front_word};

endmodule
